### hdl/frame_ring_allocator_assert.svh
// assertion macros for the frame ring allocator rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef FRAME_RING_ALLOCATOR_ASSERT_SVH
`define FRAME_RING_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define FRA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("frame_ring_allocator assertion failed");
// consequent holds in the cycle after the antecedent
`define FRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame_ring_allocator assertion failed");
`else
`define FRA_ASSERT(label, clk, rst, prop)
`define FRA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/fra_pkg.sv
// shared constants of the frame ring allocator: defaults, field widths and codes
// no dependencies; imported by frame_ring_allocator and frame_ring_allocator_test
package fra_pkg;

   // default sizing
   localparam int POOL_BYTES_DEF   = 32768;
   localparam int HEADER_BYTES_DEF = 64;
   localparam int MAX_FRAMES_DEF   = 64;

   // item field widths
   localparam int REQ_TYPE_W = 2;
   localparam int CHAN_W     = 14;
   localparam int INDEX_W    = 6;
   localparam int STATUS_W   = 3;
   localparam int ADDR_W     = 15;
   localparam int LEN_W      = 16;
   localparam int EVICT_W    = 7;
   localparam int HELD_W     = 7;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_STORE  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

endpackage

### hdl/frame_ring_allocator.sv
// frame ring allocator: places variable-size frames in a circular byte pool
// depends on fra_pkg and frame_ring_allocator_assert.svh
//
// usage
//  - req channel: one item per request; tuser carries the request kind
//    (store, lookup, clear), tdata the channel byte count and lookup index
//  - rsp channel: exactly one item per request with status, frame address,
//    frame length, evicted count and frames held afterwards
//  - sequence: clear, reject and unused codes pass the result registers to the
//    output register; lookup first reads its descriptor; a store places at once
//    into an empty store, else reads the newest, then the oldest descriptor and
//    evicts oldest frames one at a time, through the single descriptor memory
//    read port and free-space compare, until the frame fits or none is left
//  - throughput: one request at a time; req_tready is high only while the
//    sequencer is idle
//  - a finished item waits in the output register; the next request is taken
//    meanwhile and only its completion waits for rsp_tready
//  - reset clears the frame count, the ring pointer and the output valid;
//    descriptor memory content is not cleared and never read before written
`include "frame_ring_allocator_assert.svh"

module frame_ring_allocator #(
   parameter int POOL_BYTES   = fra_pkg::POOL_BYTES_DEF,
   parameter int HEADER_BYTES = fra_pkg::HEADER_BYTES_DEF,
   parameter int MAX_FRAMES   = fra_pkg::MAX_FRAMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata from bit 0: channel_bytes[13:0], index_from_end[19:14], zero fill
   input  logic [fra_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser from bit 0: req_type[1:0]
   input  logic [fra_pkg::REQ_TYPE_W-1:0]   req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata from bit 0: frame_address[14:0], frame_length[30:15],
   // evicted_frames[37:31], frames_held[44:38], zero fill
   output logic [fra_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tuser from bit 0: status[2:0]
   output logic [fra_pkg::STATUS_W-1:0]     rsp_tuser
);
   import fra_pkg::*;

   // byte address and length width inside the pool
   localparam int AW   = $clog2(POOL_BYTES + 1);
   // descriptor slot index and frame count widths
   localparam int SW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNTW = $clog2(MAX_FRAMES + 1);
   localparam int PW   = CNTW + 1;
   // signed width for free-space math
   localparam int CW   = ((AW > LEN_W) ? AW : LEN_W) + 2;
   localparam int IXW  = (INDEX_W > CNTW) ? INDEX_W : CNTW;
   localparam int DW   = 2 * AW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NEW,
      S_OLD,
      S_PLACE,
      S_LOOK,
      S_DONE
   } state_type;

   // ring index wrap for sums below twice the ring size
   function automatic logic [SW-1:0] ring_wrap(input logic [PW-1:0] v);
      logic [PW-1:0] w;
      w = (v >= PW'(MAX_FRAMES)) ? (v - PW'(MAX_FRAMES)) : v;
      return w[SW-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [CNTW-1:0]      held_ff, held_in;
   logic [SW-1:0]        oldest_ff, oldest_in;
   logic [CNTW-1:0]      evict_ff, evict_in;
   logic [LEN_W-1:0]     size_ff, size_in;
   logic [AW-1:0]        na_ff, na_in;
   logic [AW-1:0]        nl_ff, nl_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [AW-1:0]        res_addr_ff, res_addr_in;
   logic [AW-1:0]        res_len_ff, res_len_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [EVICT_W-1:0]   rsp_evict_ff, rsp_evict_in;
   logic [HELD_W-1:0]    rsp_held_ff, rsp_held_in;

   // descriptor memory: {address, length} per slot
   logic [DW-1:0]        slot_mem [MAX_FRAMES];
   logic [DW-1:0]        rd_data_ff;
   logic                 rd_en;
   logic [SW-1:0]        rd_addr;
   logic                 wr_en;
   logic [SW-1:0]        wr_addr;
   logic [DW-1:0]        wr_data;

   // request fields
   logic [CHAN_W-1:0]     chan_bytes;
   logic [INDEX_W-1:0]    index_from_end;
   logic                  req_fire;
   logic [CW-1:0]         size_calc;
   logic                  too_large;
   logic                  index_hit;

   // ring pointers
   logic [SW-1:0]         newest_slot;
   logic [SW-1:0]         look_slot;
   logic [SW-1:0]         oldest_next;

   // free-space compare
   logic [AW-1:0]         fa, fl;
   logic signed [CW-1:0]  s_fa, s_fl, s_na, s_nl, s_last, free_bytes;
   logic                  need_evict;

   // placement
   logic                  ring_full;
   logic [CNTW-1:0]       held_a;
   logic [SW-1:0]         oldest_a;
   logic [CW-1:0]         place_sum;
   logic [AW-1:0]         place;
   logic                  rsp_free;

   assign chan_bytes     = req_tdata[CHAN_W-1:0];
   assign index_from_end = req_tdata[CHAN_W+INDEX_W-1:CHAN_W];
   assign req_tready     = (state_ff == S_IDLE);
   assign req_fire       = req_tvalid && req_tready;

   assign size_calc = CW'(HEADER_BYTES) + (CW'(chan_bytes) << 1);
   assign too_large = size_calc > CW'(POOL_BYTES);
   assign index_hit = IXW'(index_from_end) < IXW'(held_ff);

   assign newest_slot = ring_wrap(PW'(oldest_ff) + PW'(held_ff) - PW'(1));
   assign look_slot   = ring_wrap(PW'(oldest_ff) + PW'(held_ff) - PW'(1)
                                  - PW'(index_from_end));
   assign oldest_next = ring_wrap(PW'(oldest_ff) + PW'(1));

   // oldest descriptor sits in the read register while in S_OLD
   assign fa     = rd_data_ff[DW-1:AW];
   assign fl     = rd_data_ff[AW-1:0];
   assign s_fa   = $signed(CW'(fa));
   assign s_fl   = $signed(CW'(fl));
   assign s_na   = $signed(CW'(na_ff));
   assign s_nl   = $signed(CW'(nl_ff));
   assign s_last = $signed(CW'(POOL_BYTES - 1));

   // free-space rule between oldest and newest frame, may go negative
   always_comb begin
      if (fa == na_ff) begin
         free_bytes = s_last - s_fa - s_fl;
      end else if (fa < na_ff) begin
         free_bytes = (fa == '0) ? (s_last - s_na - s_nl) : s_fa;
      end else begin
         free_bytes = s_fa - s_na - s_nl;
      end
   end
   assign need_evict = free_bytes < $signed(CW'(size_ff));

   // full descriptor ring drops one more oldest frame before placement
   assign ring_full = held_ff >= CNTW'(MAX_FRAMES);
   assign held_a    = ring_full ? (held_ff - CNTW'(1)) : held_ff;
   assign oldest_a  = ring_full ? oldest_next : oldest_ff;
   assign place_sum = CW'(na_ff) + CW'(nl_ff);

   // start at the pool start when the store is empty, and wrap to it when the frame would pass the last byte
   always_comb begin
      if (held_a == '0) begin
         place = '0;
      end else if (place_sum + CW'(size_ff) > CW'(POOL_BYTES - 1)) begin
         place = '0;
      end else begin
         place = AW'(place_sum);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      oldest_in     = oldest_ff;
      evict_in      = evict_ff;
      size_in       = size_ff;
      na_in         = na_ff;
      nl_in         = nl_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_len_in    = res_len_ff;
      rd_en         = 1'b0;
      rd_addr       = oldest_ff;
      wr_en         = 1'b0;
      wr_addr       = ring_wrap(PW'(oldest_a) + PW'(held_a));
      wr_data       = {place, AW'(size_ff)};
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_held_in   = rsp_held_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               evict_in      = '0;
               res_addr_in   = '0;
               res_len_in    = '0;
               res_status_in = ST_NOT_FOUND;
               size_in       = LEN_W'(size_calc);
               state_in      = S_DONE;
               case (req_tuser)
                  REQ_STORE: begin
                     if (too_large) begin
                        res_status_in = ST_REJECTED;
                     end else if (held_ff == '0) begin
                        state_in = S_PLACE;
                     end else begin
                        // fetch newest descriptor first
                        rd_en    = 1'b1;
                        rd_addr  = newest_slot;
                        state_in = S_NEW;
                     end
                  end
                  REQ_LOOKUP: begin
                     if (index_hit) begin
                        rd_en    = 1'b1;
                        rd_addr  = look_slot;
                        state_in = S_LOOK;
                     end
                  end
                  REQ_CLEAR: begin
                     held_in       = '0;
                     oldest_in     = '0;
                     res_status_in = ST_CLEARED;
                  end
                  default: begin
                     res_status_in = ST_NOT_FOUND;
                  end
               endcase
            end
         end
         S_NEW: begin
            na_in    = rd_data_ff[DW-1:AW];
            nl_in    = rd_data_ff[AW-1:0];
            rd_en    = 1'b1;
            rd_addr  = oldest_ff;
            state_in = S_OLD;
         end
         S_OLD: begin
            // one eviction per cycle until the new frame fits or the store is empty
            if (need_evict) begin
               evict_in = evict_ff + CNTW'(1);
               held_in  = held_ff - CNTW'(1);
               if (held_ff == CNTW'(1)) begin
                  oldest_in = '0;
                  state_in  = S_PLACE;
               end else begin
                  oldest_in = oldest_next;
                  rd_en     = 1'b1;
                  rd_addr   = oldest_next;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en         = 1'b1;
            held_in       = held_a + CNTW'(1);
            oldest_in     = oldest_a;
            evict_in      = ring_full ? (evict_ff + CNTW'(1)) : evict_ff;
            res_status_in = ST_STORED;
            res_addr_in   = place;
            res_len_in    = AW'(size_ff);
            state_in      = S_DONE;
         end
         S_LOOK: begin
            res_status_in = ST_FOUND;
            res_addr_in   = rd_data_ff[DW-1:AW];
            res_len_in    = rd_data_ff[AW-1:0];
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hand over to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = ADDR_W'(res_addr_ff);
               rsp_len_in    = LEN_W'(res_len_ff);
               rsp_evict_in  = EVICT_W'(evict_ff);
               rsp_held_in   = HELD_W'(held_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      evict_ff      <= evict_in;
      size_ff       <= size_in;
      na_ff         <= na_in;
      nl_ff         <= nl_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_held_ff   <= rsp_held_in;
   end

   // descriptor memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_held_ff, rsp_evict_ff, rsp_len_ff, rsp_addr_ff};

   // checks
   `FRA_ASSERT(a_held_bound, clock, reset, held_ff <= CNTW'(MAX_FRAMES))
   `FRA_ASSERT(a_empty_ptr, clock, reset, (held_ff != '0) || (oldest_ff == '0))
   `FRA_ASSERT(a_evict_nonempty, clock, reset, (state_ff != S_OLD) || (held_ff != '0))
   `FRA_ASSERT(a_store_in_pool, clock, reset,
      !((state_ff == S_DONE) && (res_status_ff == ST_STORED)) ||
      (CW'(res_addr_ff) + CW'(res_len_ff) <= CW'(POOL_BYTES)))
   `FRA_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != S_IDLE)

endmodule

### test/frame_ring_allocator_test.sv
`timescale 1ns / 1ps
// self-checking bench for frame_ring_allocator: driver, monitor, frame pool predictor
// depends on fra_pkg and the frame_ring_allocator rtl
module frame_ring_allocator_test;
   import fra_pkg::*;

   localparam int POOL  = POOL_BYTES_DEF;
   localparam int HDR   = HEADER_BYTES_DEF;
   localparam int SLOTS = MAX_FRAMES_DEF;

   // request code with no function, answered as not found
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 750;
   // slowest store plus stalls on both sides, several times over
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [CHAN_W-1:0]     chan_bytes;
      logic [INDEX_W-1:0]    index;
   } frame_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [EVICT_W-1:0]  evicted;
      logic [HELD_W-1:0]   held;
   } frame_reply_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TYPE_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   frame_ring_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // frame pool predictor: descriptor ring plus oldest pointer and count
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] slot_addr [SLOTS];
   logic [LEN_W-1:0]  slot_len  [SLOTS];
   logic [INDEX_W-1:0] oldest_idx  = '0;
   logic [HELD_W-1:0]  held_frames = '0;

   // run statistics for the summary
   int store_count, reject_count, eviction_count, ring_full_count;
   int lookup_count, found_count, clear_count, peak_held;

   function automatic int newest_idx();
      return (int'(oldest_idx) + int'(held_frames) - 1) % SLOTS;
   endfunction

   // free bytes in front of the newest frame; may go negative
   function automatic int pool_free_bytes();
      int first_a, newest_a, newest_l, n;
      if (held_frames == 0)
         return POOL;
      n        = newest_idx();
      first_a  = int'(slot_addr[oldest_idx]);
      newest_a = int'(slot_addr[n]);
      newest_l = int'(slot_len[n]);
      if (first_a == newest_a)
         return POOL - 1 - first_a - int'(slot_len[oldest_idx]);
      if (first_a < newest_a)
         return (first_a == 0) ? POOL - 1 - newest_a - newest_l : first_a;
      return first_a - newest_a - newest_l;
   endfunction

   // dropping the only frame leaves an empty store with the pointer back at 0
   function automatic void drop_oldest();
      oldest_idx  = INDEX_W'((int'(oldest_idx) + 1) % SLOTS);
      held_frames = held_frames - 1'b1;
      if (held_frames == 0)
         oldest_idx = '0;
   endfunction

   // applies one request to the pool and returns the reply it must produce
   function automatic frame_reply_type serve_request(frame_request_type rq);
      frame_reply_type r;
      int size, place, n, slot;
      r = '0;
      r.status = ST_NOT_FOUND;
      case (rq.kind)
         REQ_STORE: begin
            store_count++;
            size = HDR + 2 * int'(rq.chan_bytes);
            if (size > POOL) begin
               // frame can never fit, nothing changes
               r.status = ST_REJECTED;
               reject_count++;
            end else begin
               while (held_frames != 0 && pool_free_bytes() < size) begin
                  drop_oldest();
                  r.evicted = r.evicted + 1'b1;
               end
               // descriptor ring full after making room
               if (int'(held_frames) >= SLOTS) begin
                  drop_oldest();
                  r.evicted = r.evicted + 1'b1;
                  ring_full_count++;
               end
               if (held_frames == 0) begin
                  place = 0;
               end else begin
                  n = newest_idx();
                  place = int'(slot_addr[n]) + int'(slot_len[n]);
                  // would run past the last pool byte: wrap to the start
                  if (place + size > POOL - 1)
                     place = 0;
               end
               slot = (int'(oldest_idx) + int'(held_frames)) % SLOTS;
               slot_addr[slot] = place[ADDR_W-1:0];
               slot_len[slot]  = size[LEN_W-1:0];
               held_frames     = held_frames + 1'b1;
               r.status  = ST_STORED;
               r.address = place[ADDR_W-1:0];
               r.length  = size[LEN_W-1:0];
               eviction_count += int'(r.evicted);
            end
         end
         REQ_LOOKUP: begin
            lookup_count++;
            if (HELD_W'(rq.index) < held_frames) begin
               slot = (int'(oldest_idx) + int'(held_frames) - 1 - int'(rq.index)) % SLOTS;
               r.status  = ST_FOUND;
               r.address = slot_addr[slot];
               r.length  = slot_len[slot];
               found_count++;
            end
         end
         REQ_CLEAR: begin
            held_frames = '0;
            oldest_idx  = '0;
            r.status    = ST_CLEARED;
            clear_count++;
         end
         default: ;
      endcase
      r.held = held_frames;
      if (int'(held_frames) > peak_held)
         peak_held = int'(held_frames);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // stimulus store, idle rates per phase
   // ---------------------------------------------------------------
   frame_request_type request_backlog [$];
   frame_reply_type   pending_replies [$];
   frame_request_type drive_item;
   frame_reply_type   expected_reply;
   int total_items, accepted_count, error_count, cycle_count;

   // phase one: sender idles 38 of 100, receiver 58; phase two swapped; then none
   function automatic int sender_idle_pct();
      if (accepted_count < total_items / 3)
         return 38;
      if (accepted_count < 2 * total_items / 3)
         return 58;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (accepted_count < total_items / 3)
         return 58;
      if (accepted_count < 2 * total_items / 3)
         return 38;
      return 0;
   endfunction

   function automatic void queue_request(logic [REQ_TYPE_W-1:0] kind, int chan, int index);
      frame_request_type rq;
      rq.kind       = kind;
      rq.chan_bytes = chan[CHAN_W-1:0];
      rq.index      = index[INDEX_W-1:0];
      request_backlog.push_back(rq);
   endfunction

   // mixed request; channel sizes lean small so the ring fills up
   function automatic void queue_random_request();
      int roll, chan, index;
      roll = $urandom_range(99);
      if (roll < 55)
         chan = $urandom_range(255);
      else if (roll < 80)
         chan = $urandom_range(4095);
      else if (roll < 95)
         chan = $urandom_range(16383);
      else begin
         case ($urandom_range(4))
            0:       chan = 0;
            1:       chan = 16351;
            2:       chan = 16352;
            3:       chan = 16353;
            default: chan = 16383;
         endcase
      end
      index = $urandom_range(1) ? $urandom_range(7) : $urandom_range(63);
      roll = $urandom_range(99);
      if (roll < 68)
         queue_request(REQ_STORE, chan, index);
      else if (roll < 95)
         queue_request(REQ_LOOKUP, chan, index);
      else if (roll < 96)
         queue_request(REQ_CLEAR, chan, index);
      else
         queue_request(REQ_UNUSED, chan, index);
   endfunction

   // ---------------------------------------------------------------
   // request driver: holds an item until taken, idles only between items
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_replies.push_back(serve_request(drive_item));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               drive_item = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= drive_item.kind;
               req_tdata  <= {{(REQ_TDATA_W - CHAN_W - INDEX_W){1'b0}},
                              drive_item.index, drive_item.chan_bytes};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
   end

   // ---------------------------------------------------------------
   // response monitor
   // ---------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            expected_reply = pending_replies.pop_front();
            check_field("status", 32'(expected_reply.status), 32'(rsp_tuser));
            check_field("frame_address", 32'(expected_reply.address),
                        32'(rsp_tdata[14:0]));
            check_field("frame_length", 32'(expected_reply.length),
                        32'(rsp_tdata[30:15]));
            check_field("evicted_frames", 32'(expected_reply.evicted),
                        32'(rsp_tdata[37:31]));
            check_field("frames_held", 32'(expected_reply.held),
                        32'(rsp_tdata[44:38]));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int random_count, burst_len;
      // empty store: lookup misses, unused code
      queue_request(REQ_LOOKUP, 0, 0);
      queue_request(REQ_UNUSED, 16383, 63);
      // smallest frame, then frames beyond the pool
      queue_request(REQ_STORE, 0, 0);
      queue_request(REQ_STORE, 16383, 63);
      queue_request(REQ_STORE, 16353, 0);
      queue_request(REQ_LOOKUP, 0, 0);
      queue_request(REQ_LOOKUP, 0, 63);
      queue_request(REQ_LOOKUP, 0, 1);
      // frame exactly the pool size evicts the only frame, next store evicts it in turn
      queue_request(REQ_STORE, 16352, 0);
      queue_request(REQ_STORE, 100, 0);
      // large frames force wrap to address 0 and eviction of older ones
      queue_request(REQ_STORE, 8000, 0);
      queue_request(REQ_STORE, 8000, 0);
      queue_request(REQ_STORE, 8000, 0);
      queue_request(REQ_LOOKUP, 0, 1);
      queue_request(REQ_LOOKUP, 0, 2);
      queue_request(REQ_CLEAR, 0, 0);
      queue_request(REQ_LOOKUP, 0, 0);
      queue_request(REQ_STORE, 16351, 0);
      queue_request(REQ_STORE, 0, 0);
      queue_request(REQ_LOOKUP, 16383, 0);
      queue_request(REQ_CLEAR, 16383, 63);
      queue_request(REQ_UNUSED, 0, 0);

      // random part; bursts of small stores fill the descriptor ring past its size
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         if ($urandom_range(39) == 0) begin
            burst_len = $urandom_range(72, 64);
            for (int i = 0; i < burst_len; i++)
               queue_request(REQ_STORE, $urandom_range(31), $urandom_range(63));
            random_count += burst_len;
         end else begin
            queue_random_request();
            random_count++;
         end
      end
      total_items = request_backlog.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // every item taken and every reply seen
      while (accepted_count < total_items || pending_replies.size() != 0)
         @(posedge clock);
      // catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests, %0d stores (%0d rejected), %0d evictions, %0d on full ring",
               accepted_count, store_count, reject_count, eviction_count, ring_full_count);
      $display("run: %0d lookups (%0d hits), %0d clears, at most %0d frames held, %0d errors",
               lookup_count, found_count, clear_count, peak_held, error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
